// File: rtl/core/sfd_pkg.sv
// Package for the serial radio-control frame decoder: frame constants,
// field widths and the result packing function. No dependencies.
`default_nettype none

package sfd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CHAN_W     = 11;
   localparam int unsigned NUM_CHAN   = 5;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned POS_W      = 5;

   localparam logic [POS_W-1:0]  FRAME_LAST   = POS_W'(24);
   localparam logic [POS_W-1:0]  FAILSAFE_POS = POS_W'(23);
   localparam int unsigned       CHAN_BYTES   = 7;

   localparam logic [BYTE_W-1:0] START_BYTE   = 8'h0F;
   localparam logic [BYTE_W-1:0] END_BYTE     = 8'h00;
   localparam int unsigned       FAILSAFE_BIT = 3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      logic     signal_ok;
      chan_type chan_e;
      chan_type chan_d;
      chan_type chan_c;
      chan_type chan_b;
      chan_type chan_a;
   } rsp_type;

   // Unpack channels 0..4 from frame bytes 1..7 (element 0 is byte 1).
   function automatic rsp_type unpack_frame(input byte_type d [CHAN_BYTES],
                                            input logic failsafe);
      rsp_type r;
      r.chan_a    = {d[1][2:0], d[0]};
      r.chan_b    = {d[2][5:0], d[1][7:3]};
      r.chan_c    = {d[4][0], d[3], d[2][7:6]};
      r.chan_d    = {d[5][3:0], d[4][7:1]};
      r.chan_e    = {d[6][6:0], d[5][7:4]};
      r.signal_ok = ~failsafe;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/sbus_frame_decoder_core.sv
// Serial radio-control frame decoder: input beat register, frame tracker
// and result register. Depends on sfd_pkg.
//
// Takes one received byte per beat and gives one beat per good 25-byte
// frame (start byte 0x0F, end byte 0x00), carrying channels 0..4 and the
// inverse of the failsafe flag. Bytes before a start byte are dropped; a
// frame with a bad end byte yields nothing. One byte is accepted every
// clock cycle while the result side takes beats; an accepted end byte waits in
// the input register, and its result is set by the result register that
// the frame tracker loads from the input register.
`default_nettype none

module sbus_frame_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // [10:0] chan_a, [21:11] chan_b,
                                         // [32:22] chan_c, [43:33] chan_d,
                                         // [54:44] chan_e, [55] signal_ok
);

   logic                     in_valid_ff, in_valid_in;
   sfd_pkg::byte_type        in_byte_ff;
   logic [sfd_pkg::POS_W-1:0] pos_ff, pos_in;
   sfd_pkg::byte_type        chan_byte_ff [sfd_pkg::CHAN_BYTES];
   logic                     failsafe_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   sfd_pkg::rsp_type         rsp_data_ff;

   logic                     consume;
   logic                     drop_idle;
   logic                     at_end;
   logic                     emit;

   assign consume    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign drop_idle  = (pos_ff == '0) && (in_byte_ff != sfd_pkg::START_BYTE);
   assign at_end     = (pos_ff >= sfd_pkg::FRAME_LAST);
   assign emit       = consume && !drop_idle && at_end
                       && (in_byte_ff == sfd_pkg::END_BYTE);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (consume && !drop_idle) begin
         if (at_end) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (consume && !drop_idle && !at_end) begin
         for (int i = 0; i < sfd_pkg::CHAN_BYTES; i++) begin
            if (pos_ff == sfd_pkg::POS_W'(i + 1)) begin
               chan_byte_ff[i] <= in_byte_ff;
            end
         end
         if (pos_ff == sfd_pkg::FAILSAFE_POS) begin
            failsafe_ff <= in_byte_ff[sfd_pkg::FAILSAFE_BIT];
         end
      end
      if (emit) begin
         rsp_data_ff <= sfd_pkg::unpack_frame(chan_byte_ff, failsafe_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= sfd_pkg::FRAME_LAST)
      else $error("byte position beyond frame length");

   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result raised without a completed good frame");

   a_idle_drop : assert property (@(posedge clock) disable iff (reset)
      consume && drop_idle |=> pos_ff == '0)
      else $error("idle byte advanced the frame position");

   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost or changed");

   a_end_wrap : assert property (@(posedge clock) disable iff (reset)
      consume && !drop_idle && at_end |=> pos_ff == '0)
      else $error("frame position not restarted after end byte");

endmodule

`default_nettype wire

// File: tb/sv/sbus_frame_decoder_checker.sv
// Checker for the serial radio-control frame decoder. It watches both streams,
// tracks the frame in its own model and compares every result beat.
// Depends on sfd_pkg.

module sbus_frame_decoder_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,   // [10:0] chan_a .. [54:44] chan_e, [55] signal_ok
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES = int'(sfd_pkg::FRAME_LAST) + 1;

   sfd_pkg::byte_type         frame_bytes [FRAME_BYTES];
   logic [sfd_pkg::POS_W-1:0] fill_level;
   sfd_pkg::rsp_type          decoded_q [$];

   initial fail_count = 0;
   initial pending = 0;

   task automatic report_fault(input string msg);
      $display("%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Channels sit as one little-endian bit stream starting at byte 1.
   function automatic sfd_pkg::rsp_type decode_channels(
         input sfd_pkg::byte_type fb [FRAME_BYTES]);
      logic [55:0]      stream;
      sfd_pkg::rsp_type r;
      stream      = {fb[7], fb[6], fb[5], fb[4], fb[3], fb[2], fb[1]};
      r.chan_a    = stream[10:0];
      r.chan_b    = stream[21:11];
      r.chan_c    = stream[32:22];
      r.chan_d    = stream[43:33];
      r.chan_e    = stream[54:44];
      r.signal_ok = ~fb[sfd_pkg::FAILSAFE_POS][sfd_pkg::FAILSAFE_BIT];
      return r;
   endfunction

   task automatic track_byte(input sfd_pkg::byte_type b);
      if (fill_level == '0 && b != sfd_pkg::START_BYTE) begin
         return;
      end
      if (fill_level < sfd_pkg::FRAME_LAST) begin
         frame_bytes[fill_level] = b;
         fill_level = fill_level + 1'b1;
      end else begin
         frame_bytes[sfd_pkg::FRAME_LAST] = b;
         fill_level = '0;
         if (b == sfd_pkg::END_BYTE) begin
            decoded_q.push_back(decode_channels(frame_bytes));
         end
      end
   endtask

   task automatic compare_beat(input sfd_pkg::rsp_type got);
      sfd_pkg::rsp_type want;
      if (decoded_q.size() == 0) begin
         report_fault($sformatf("unexpected result beat %h", got));
         return;
      end
      want = decoded_q.pop_front();
      if (got.chan_a !== want.chan_a)
         report_fault($sformatf("chan_a got %0d want %0d", got.chan_a, want.chan_a));
      if (got.chan_b !== want.chan_b)
         report_fault($sformatf("chan_b got %0d want %0d", got.chan_b, want.chan_b));
      if (got.chan_c !== want.chan_c)
         report_fault($sformatf("chan_c got %0d want %0d", got.chan_c, want.chan_c));
      if (got.chan_d !== want.chan_d)
         report_fault($sformatf("chan_d got %0d want %0d", got.chan_d, want.chan_d));
      if (got.chan_e !== want.chan_e)
         report_fault($sformatf("chan_e got %0d want %0d", got.chan_e, want.chan_e));
      if (got.signal_ok !== want.signal_ok)
         report_fault($sformatf("signal_ok got %b want %b", got.signal_ok, want.signal_ok));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill_level = '0;
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_beat(sfd_pkg::rsp_type'(rsp_tdata));
         end
      end
      pending <= decoded_q.size();
   end

endmodule

// File: tb/sv/sbus_frame_decoder_core_tb.sv
// Top of the frame decoder testbench: clock, reset, byte stimulus, result
// back-pressure, stall watchdog and verdict. Depends on sfd_pkg, the decoder
// core and sbus_frame_decoder_checker.

module sbus_frame_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES = int'(sfd_pkg::FRAME_LAST) + 1;
   localparam int BYTE_TARGET = 1850;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;           // [10:0] chan_a .. [54:44] chan_e, [55] signal_ok

   int fail_count;
   int pending;
   int bytes_sent = 0;
   int stall_cycles = 0;
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;

   always #1 clock = ~clock;

   sbus_frame_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sbus_frame_decoder_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_byte(input sfd_pkg::byte_type b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Hold off until every decoded frame has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_frame(input bit good_end, input int pattern);
      sfd_pkg::byte_type fr [FRAME_BYTES];
      for (int k = 1; k < FRAME_BYTES - 1; k++) begin
         case (pattern)
            1: fr[k] = 8'hFF;
            2: fr[k] = 8'h00;
            3: fr[k] = ($urandom_range(0, 5) == 0) ? sfd_pkg::START_BYTE
                                                   : sfd_pkg::byte_type'($urandom);
            default: fr[k] = sfd_pkg::byte_type'($urandom);
         endcase
      end
      fr[0] = sfd_pkg::START_BYTE;
      fr[sfd_pkg::FRAME_LAST] = good_end ? sfd_pkg::END_BYTE
                                         : sfd_pkg::byte_type'($urandom_range(1, 255));
      for (int k = 0; k < FRAME_BYTES; k++) begin
         send_byte(fr[k]);
      end
   endtask

   initial begin : stimulus
      int pick;
      int burst;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle noise, then a frame of all ones carrying a start byte mid-frame
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sfd_pkg::START_BYTE);
      for (int k = 1; k < FRAME_BYTES - 1; k++) begin
         send_byte(k == 3 ? sfd_pkg::START_BYTE : 8'hFF);
      end
      send_byte(sfd_pkg::END_BYTE);
      drain_results();

      calm = 1'b1;
      hold_rsp = 1'b1;
      repeat (6) send_frame(1'b1, $urandom_range(0, 3));
      calm = 1'b0;
      drain_results();

      while (bytes_sent < BYTE_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               send_byte(($urandom_range(0, 7) == 0) ? sfd_pkg::START_BYTE
                                                     : sfd_pkg::byte_type'($urandom));
            end
         end else begin
            send_frame($urandom_range(0, 4) != 0, $urandom_range(0, 5) % 4);
         end
         if ($urandom_range(0, 19) == 0) begin
            drain_results();
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : rsp_side
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule

// File: filelist.f
rtl/core/sfd_pkg.sv
rtl/core/sbus_frame_decoder_core.sv
tb/sv/sbus_frame_decoder_checker.sv
tb/sv/sbus_frame_decoder_core_tb.sv
